// ===== hdl/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants for the WAV header parser: chunk ids, the
// controller state encoding and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    // Chunk and form ids as little-endian 32-bit words
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // Result payload widths
    localparam int unsigned CHAN_W = 16;
    localparam int unsigned BPS_W  = 13;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned BITS_W = 16;
    localparam int unsigned OUT_DATA_W = 128;

    // Controller states, one per header field plus skip, done and check
    typedef enum logic [15:0] {
        ST_RIFF_ID    = 16'h0001,
        ST_RIFF_SIZE  = 16'h0002,
        ST_WAVE       = 16'h0004,
        ST_FMT_ID     = 16'h0008,
        ST_FMT_SIZE   = 16'h0010,
        ST_FORMAT     = 16'h0020,
        ST_CHANNELS   = 16'h0040,
        ST_RATE       = 16'h0080,
        ST_BYTE_RATE  = 16'h0100,
        ST_ALIGN      = 16'h0200,
        ST_BITS       = 16'h0400,
        ST_CHUNK_ID   = 16'h0800,
        ST_CHUNK_SIZE = 16'h1000,
        ST_SKIP       = 16'h2000,
        ST_DONE       = 16'h4000,
        ST_CHECK      = 16'h8000
    } t_state;

    typedef struct packed {
        logic       take;          // byte transaction this cycle
        logic       clear;         // end of file: back to a fresh file
        logic       acc;           // byte belongs to a header field
        logic [1:0] byte_idx;      // byte position inside the field
        logic       field_last;    // byte completes the field
        logic       cap_channels;
        logic       cap_rate;
        logic       cap_byte_rate;
        logic       cap_align;
        logic       cap_bits;
        logic       load_skip;
        logic       dec_skip;
        logic       emit_ok;       // load a valid result
        logic       emit_bad;      // load an invalid result
    } t_dp_cmd;

    typedef struct packed {
        logic id_riff;
        logic id_wave;
        logic id_fmt;
        logic id_data;
        logic val_zero;
        logic skip_last;
        logic fmt_ok;
    } t_dp_status;

    // Index of the last byte of the field read in a state
    function automatic logic [1:0] field_last_idx(input t_state s);
        logic [1:0] r;
        case (s)
            ST_FORMAT, ST_CHANNELS, ST_ALIGN, ST_BITS: r = 2'd1;
            ST_SKIP, ST_DONE, ST_CHECK:                r = 2'd0;
            default:                                   r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_header_parser
// Parses a WAV header from a byte stream and reports format and data chunk.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; input holds in the check state after the bits field
//   while the fmt check runs through its multipliers, and outside the done state also
//   while a result waits in the output register and the receiver is not ready.
// Output: the result is registered in the cycle after the byte that completes
//   the data header; an fmt failure is loaded from the check state once the slot is free.
// Reset: synchronous, active low; parser expects a RIFF id, result slot empty.
// ----------------------------------------------------------------------------
module wav_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [15:0] channel_count, [28:16] bytes_per_sample,
                                         // [60:29] sample_rate, [92:61] data_offset,
                                         // [124:93] data_size, [127:125] zero
    output logic         m_axis_tuser    // status
);
    import wavhp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [15:0] channel_count;
    logic [12:0] bytes_per_sample;
    logic [31:0] sample_rate;
    logic [31:0] data_offset;
    logic [31:0] data_size;

    wavhp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wavhp_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_byte             (s_axis_tdata),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_out_status       (m_axis_tuser),
        .o_channel_count    (channel_count),
        .o_bytes_per_sample (bytes_per_sample),
        .o_sample_rate      (sample_rate),
        .o_data_offset      (data_offset),
        .o_data_size        (data_size)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {3'd0, data_size, data_offset, sample_rate,
                           bytes_per_sample, channel_count};

    // Never load a valid and an invalid result together
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.emit_ok && cmd.emit_bad))
        else $error("valid and invalid result loaded together");

    // Load a result only into a free or draining slot
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_ok || cmd.emit_bad) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending result");

    // A loaded result is offered in the next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_ok || cmd.emit_bad) |=> m_axis_tvalid)
        else $error("loaded result not offered");

    // A valid result only on a byte transaction
    a_ok_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_ok |-> (s_axis_tvalid && s_axis_tready))
        else $error("valid result without a byte transaction");

endmodule

// ===== hdl/wavhp_dpath.sv =====
// ----------------------------------------------------------------------------
// wavhp_dpath
// Datapath of the WAV header parser: field accumulator, byte counter, skip
// counter, held fmt fields, the fmt consistency check and the result register.
// ----------------------------------------------------------------------------
module wavhp_dpath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_byte,
    input  wavhp_pkg::t_dp_cmd     i_cmd,
    output wavhp_pkg::t_dp_status  o_status,
    output logic                   o_out_status,
    output logic [15:0]            o_channel_count,
    output logic [12:0]            o_bytes_per_sample,
    output logic [31:0]            o_sample_rate,
    output logic [31:0]            o_data_offset,
    output logic [31:0]            o_data_size
);
    import wavhp_pkg::*;

    logic [WORD_W-1:0] r_shift;
    logic [WORD_W-1:0] r_count;
    logic [WORD_W-1:0] r_skip;
    logic [CHAN_W-1:0] r_channels;
    logic [WORD_W-1:0] r_rate;
    logic [WORD_W-1:0] r_byte_rate;
    logic [BITS_W-1:0] r_align;
    logic [BITS_W-1:0] r_bits;
    logic [WORD_W-1:0] r_rate_chan;

    logic [WORD_W-1:0] field_val;
    logic [WORD_W-1:0] n_count;
    logic [WORD_W-1:0] rate_prod;
    logic [WORD_W-1:0] align_prod;

    // Merge the incoming byte into the little-endian field word
    assign field_val = r_shift | ({24'd0, i_byte} << {i_cmd.byte_idx, 3'b000});
    assign n_count   = (r_count == '1) ? r_count : r_count + 32'd1;

    // Products for the fmt check; rate times channels is kept ready ahead
    assign rate_prod  = WORD_W'(48'(r_rate_chan) * 48'(r_bits));
    assign align_prod = WORD_W'(r_channels) * WORD_W'(r_bits);

    assign o_status.id_riff   = (field_val == ID_RIFF);
    assign o_status.id_wave   = (field_val == ID_WAVE);
    assign o_status.id_fmt    = (field_val == ID_FMT);
    assign o_status.id_data   = (field_val == ID_DATA);
    assign o_status.val_zero  = (field_val == '0);
    assign o_status.skip_last = (r_skip == 32'd1);
    assign o_status.fmt_ok    = (r_byte_rate == {3'd0, rate_prod[WORD_W-1:3]})
                             && ({16'd0, r_align} == {3'd0, align_prod[WORD_W-1:3]});

    // Field accumulator and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_shift <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.take) begin
                r_count <= n_count;
            end
            if (i_cmd.acc) begin
                r_shift <= i_cmd.field_last ? '0 : field_val;
            end
        end
    end

    // Held fields, skip counter and the rate-times-channels product
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_channels) begin
            r_channels <= field_val[CHAN_W-1:0];
        end
        if (i_cmd.cap_rate) begin
            r_rate <= field_val;
        end
        if (i_cmd.cap_byte_rate) begin
            r_byte_rate <= field_val;
        end
        if (i_cmd.cap_align) begin
            r_align <= field_val[BITS_W-1:0];
        end
        if (i_cmd.cap_bits) begin
            r_bits <= field_val[BITS_W-1:0];
        end
        if (i_cmd.load_skip) begin
            r_skip <= field_val;
        end else if (i_cmd.dec_skip) begin
            r_skip <= r_skip - 32'd1;
        end
        r_rate_chan <= WORD_W'(48'(r_rate) * 48'(r_channels));
    end

    // Result register; an invalid result carries zeros
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ok) begin
            o_out_status       <= 1'b0;
            o_channel_count    <= r_channels;
            o_bytes_per_sample <= r_bits[BITS_W-1:3];
            o_sample_rate      <= r_rate;
            o_data_offset      <= n_count;
            o_data_size        <= field_val;
        end else if (i_cmd.emit_bad) begin
            o_out_status       <= 1'b1;
            o_channel_count    <= '0;
            o_bytes_per_sample <= '0;
            o_sample_rate      <= '0;
            o_data_offset      <= '0;
            o_data_size        <= '0;
        end
    end

endmodule

// ===== hdl/wavhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// wavhp_ctrl
// Controller of the WAV header parser: walks the header fields, tracks the
// header checks, drives the datapath and owns both stream handshakes.
// ----------------------------------------------------------------------------
module wavhp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_last,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  wavhp_pkg::t_dp_status  i_status,
    output wavhp_pkg::t_dp_cmd     o_cmd
);
    import wavhp_pkg::*;

    t_state     r_state,    n_state;
    logic [1:0] r_idx,      n_idx;
    logic       r_bad,      n_bad;
    logic       r_is_data,  n_is_data;
    logic       r_eof_pend, n_eof_pend;
    logic       r_out_valid;

    logic out_free;
    logic in_fire;
    logic last;

    // Accept bytes unless checking, or unless a result may be due while full
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state != ST_CHECK) && (out_free || r_state == ST_DONE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign last        = (r_idx == field_last_idx(r_state));
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_bad      = r_bad;
        n_is_data  = r_is_data;
        n_eof_pend = r_eof_pend;
        o_cmd          = '0;
        o_cmd.take     = in_fire;
        o_cmd.byte_idx = r_idx;

        if (r_state == ST_CHECK) begin
            if (out_free) begin
                if (r_eof_pend || r_bad || !i_status.fmt_ok) begin
                    o_cmd.emit_bad = 1'b1;
                end
                if (r_eof_pend) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_RIFF_ID;
                    n_idx       = '0;
                    n_bad       = 1'b0;
                    n_is_data   = 1'b0;
                    n_eof_pend  = 1'b0;
                end else if (r_bad || !i_status.fmt_ok) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CHUNK_ID;
                end
            end
        end else if (in_fire) begin
            if (r_state == ST_SKIP) begin
                o_cmd.dec_skip = 1'b1;
                if (i_status.skip_last) begin
                    n_state = ST_CHUNK_ID;
                end
            end else if (r_state != ST_DONE) begin
                o_cmd.acc        = 1'b1;
                o_cmd.field_last = last;
                if (!last) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx = '0;
                    case (r_state)
                        ST_RIFF_ID: begin
                            n_bad   = r_bad | !i_status.id_riff;
                            n_state = ST_RIFF_SIZE;
                        end
                        ST_RIFF_SIZE: n_state = ST_WAVE;
                        ST_WAVE: begin
                            n_bad   = r_bad | !i_status.id_wave;
                            n_state = ST_FMT_ID;
                        end
                        ST_FMT_ID: begin
                            n_bad   = r_bad | !i_status.id_fmt;
                            n_state = ST_FMT_SIZE;
                        end
                        ST_FMT_SIZE: n_state = ST_FORMAT;
                        ST_FORMAT:   n_state = ST_CHANNELS;
                        ST_CHANNELS: begin
                            o_cmd.cap_channels = 1'b1;
                            n_state            = ST_RATE;
                        end
                        ST_RATE: begin
                            o_cmd.cap_rate = 1'b1;
                            n_state        = ST_BYTE_RATE;
                        end
                        ST_BYTE_RATE: begin
                            o_cmd.cap_byte_rate = 1'b1;
                            n_state             = ST_ALIGN;
                        end
                        ST_ALIGN: begin
                            o_cmd.cap_align = 1'b1;
                            n_state         = ST_BITS;
                        end
                        ST_BITS: begin
                            o_cmd.cap_bits = 1'b1;
                            n_eof_pend     = i_in_last;
                            n_state        = ST_CHECK;
                        end
                        ST_CHUNK_ID: begin
                            n_is_data = i_status.id_data;
                            n_state   = ST_CHUNK_SIZE;
                        end
                        ST_CHUNK_SIZE: begin
                            if (r_is_data) begin
                                o_cmd.emit_ok = 1'b1;
                                n_state       = ST_DONE;
                            end else if (i_status.val_zero) begin
                                n_state = ST_CHUNK_ID;
                            end else begin
                                o_cmd.load_skip = 1'b1;
                                n_state         = ST_SKIP;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end

            // End of file: report a truncated header unless the parse is done, then start over
            if (i_in_last && n_state != ST_CHECK) begin
                if (n_state != ST_DONE) begin
                    o_cmd.emit_bad = 1'b1;
                end
                o_cmd.clear = 1'b1;
                n_state     = ST_RIFF_ID;
                n_idx       = '0;
                n_bad       = 1'b0;
                n_is_data   = 1'b0;
                n_eof_pend  = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RIFF_ID;
            r_idx       <= '0;
            r_bad       <= 1'b0;
            r_is_data   <= 1'b0;
            r_eof_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_bad       <= n_bad;
            r_is_data   <= n_is_data;
            r_eof_pend  <= n_eof_pend;
            r_out_valid <= (r_out_valid && !i_out_ready) || o_cmd.emit_ok || o_cmd.emit_bad;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for wav_header_parser. Streams WAV files byte by byte into the
// parser: a short table of truncated files, then generated files (valid,
// with bad ids, bad rate or align, truncated, with huge chunk sizes, noise).
// A behavioral bench parser predicts each header report, typed table rows apart, and
// every report from the parser is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module tb_top;

    import wavhp_pkg::*;

    // Header report as seen on the result stream
    typedef struct packed {
        logic        status;
        logic [15:0] chan;
        logic [12:0] bps;
        logic [31:0] rate;
        logic [31:0] offset;
        logic [31:0] size;
    } t_hdr_result;

    // One byte of the directed table, with a typed report where it is obvious
    typedef struct packed {
        logic [7:0]  b;
        logic        eof;
        logic        typed;
        t_hdr_result want;
    } t_dir_row;

    typedef enum int {
        FK_VALID, FK_BAD_ID, FK_BAD_RATE, FK_BAD_ALIGN, FK_TRUNC, FK_HUGE_SKIP, FK_NOISE
    } t_file_kind;

    localparam int          NUM_KINDS   = 7;
    localparam int          HOLD_CYCLES = 300;
    localparam t_hdr_result INVALID_HDR =
        t_hdr_result'({1'b1, 16'd0, 13'd0, 32'd0, 32'd0, 32'd0});
    localparam int          NUM_DIR = 15;

    // Truncated files: three lone bytes, a RIFF id and size, a wrong RIFF id
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{8'h52, 1'b1, 1'b1, INVALID_HDR},
        '{8'h00, 1'b1, 1'b1, INVALID_HDR},
        '{8'hFF, 1'b1, 1'b1, INVALID_HDR},
        '{8'h52, 1'b0, 1'b0, INVALID_HDR},
        '{8'h49, 1'b0, 1'b0, INVALID_HDR},
        '{8'h46, 1'b0, 1'b0, INVALID_HDR},
        '{8'h46, 1'b0, 1'b0, INVALID_HDR},
        '{8'hFF, 1'b0, 1'b0, INVALID_HDR},
        '{8'hFF, 1'b0, 1'b0, INVALID_HDR},
        '{8'hFF, 1'b0, 1'b0, INVALID_HDR},
        '{8'hFF, 1'b1, 1'b1, INVALID_HDR},
        '{8'h52, 1'b0, 1'b0, INVALID_HDR},
        '{8'h49, 1'b0, 1'b0, INVALID_HDR},
        '{8'h46, 1'b0, 1'b0, INVALID_HDR},
        '{8'h58, 1'b1, 1'b1, INVALID_HDR}
    };

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'd0;   // [7:0] file_byte
    logic         s_axis_tlast  = 1'b0;   // end_of_file
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;           // [15:0] chan, [28:16] bps, [60:29] rate,
                                          // [92:61] offset, [124:93] size, [127:125] zero
    logic         m_axis_tuser;           // status

    // Bench parser state
    t_state      wav_phase   = ST_RIFF_ID;
    logic [4:0]  wav_fidx    = '0;
    logic [31:0] wav_acc     = '0;
    logic [31:0] wav_count   = '0;
    logic [31:0] wav_skip    = '0;
    logic        wav_bad     = 1'b0;
    logic        wav_is_data = 1'b0;
    logic [15:0] wav_chan    = '0;
    logic [31:0] wav_rate    = '0;
    logic [31:0] wav_brate   = '0;
    logic [15:0] wav_align   = '0;
    logic [15:0] wav_bits    = '0;

    t_hdr_result header_reports_due[$];
    logic [7:0]  file_q[$];

    int send_idle_pct = 14;
    int recv_idle_pct = 70;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int errors        = 0;
    int bytes_sent    = 0;
    int files_sent    = 0;
    int reports_seen  = 0;
    int reports_valid = 0;

    wav_header_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the parser hangs
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, seen, want);
        errors++;
    endtask

    task automatic reset_parse_state();
        wav_phase   = ST_RIFF_ID;
        wav_fidx    = '0;
        wav_acc     = '0;
        wav_count   = '0;
        wav_skip    = '0;
        wav_bad     = 1'b0;
        wav_is_data = 1'b0;
        wav_chan    = '0;
        wav_rate    = '0;
        wav_brate   = '0;
        wav_align   = '0;
        wav_bits    = '0;
    endtask

    // Advance the bench parser by one byte; got is set when a report is due
    task automatic parse_wav_byte(input logic [7:0] b, input logic eof,
                                  output bit got, output t_hdr_result r);
        logic [31:0] v;
        logic [31:0] prod;
        logic [31:0] align32;
        int          flen;
        got = 1'b0;
        r   = INVALID_HDR;
        if (wav_count != 32'hFFFF_FFFF)
            wav_count++;
        case (wav_phase)
            ST_SKIP: begin
                wav_skip--;
                if (wav_skip == 0)
                    wav_phase = ST_CHUNK_ID;
            end
            ST_DONE, ST_CHECK: begin
            end
            default: begin
                wav_acc |= 32'(b) << (8 * wav_fidx[1:0]);
                flen = (wav_phase inside {ST_FORMAT, ST_CHANNELS, ST_ALIGN, ST_BITS}) ? 2 : 4;
                if (int'(wav_fidx[1:0]) + 1 < flen) begin
                    wav_fidx = 5'(wav_fidx[1:0]) + 5'd1;
                end else begin
                    v        = wav_acc;
                    wav_acc  = '0;
                    wav_fidx = '0;
                    case (wav_phase)
                        ST_RIFF_ID: begin
                            if (v != ID_RIFF) wav_bad = 1'b1;
                            wav_phase = ST_RIFF_SIZE;
                        end
                        ST_RIFF_SIZE: wav_phase = ST_WAVE;
                        ST_WAVE: begin
                            if (v != ID_WAVE) wav_bad = 1'b1;
                            wav_phase = ST_FMT_ID;
                        end
                        ST_FMT_ID: begin
                            if (v != ID_FMT) wav_bad = 1'b1;
                            wav_phase = ST_FMT_SIZE;
                        end
                        ST_FMT_SIZE: wav_phase = ST_FORMAT;
                        ST_FORMAT:   wav_phase = ST_CHANNELS;
                        ST_CHANNELS: begin
                            wav_chan  = v[15:0];
                            wav_phase = ST_RATE;
                        end
                        ST_RATE: begin
                            wav_rate  = v;
                            wav_phase = ST_BYTE_RATE;
                        end
                        ST_BYTE_RATE: begin
                            wav_brate = v;
                            wav_phase = ST_ALIGN;
                        end
                        ST_ALIGN: begin
                            wav_align = v[15:0];
                            wav_phase = ST_BITS;
                        end
                        ST_BITS: begin
                            // Both products wrap at 32 bits
                            wav_bits = v[15:0];
                            prod     = wav_rate * {16'd0, wav_chan} * {16'd0, wav_bits};
                            align32  = {16'd0, wav_chan} * {16'd0, wav_bits};
                            if (wav_brate != (prod >> 3)) wav_bad = 1'b1;
                            if ({16'd0, wav_align} != (align32 >> 3)) wav_bad = 1'b1;
                            if (wav_bad) begin
                                got       = 1'b1;
                                wav_phase = ST_DONE;
                            end else begin
                                wav_phase = ST_CHUNK_ID;
                            end
                        end
                        ST_CHUNK_ID: begin
                            wav_is_data = (v == ID_DATA);
                            wav_phase   = ST_CHUNK_SIZE;
                        end
                        ST_CHUNK_SIZE: begin
                            if (wav_is_data) begin
                                got       = 1'b1;
                                r         = {1'b0, wav_chan, wav_bits[15:3], wav_rate,
                                             wav_count, v};
                                wav_phase = ST_DONE;
                            end else if (v == 0) begin
                                wav_phase = ST_CHUNK_ID;
                            end else begin
                                wav_skip  = v;
                                wav_phase = ST_SKIP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
        // End of file reports a truncated header unless a report already went out
        if (eof) begin
            if (!got && wav_phase != ST_DONE && wav_phase != ST_CHECK)
                got = 1'b1;
            reset_parse_state();
        end
    endtask

    // Offer one byte, hold it until the transaction, then predict
    task automatic send_byte(input logic [7:0] b, input logic eof, input bit typed,
                             input t_hdr_result want);
        bit          got;
        t_hdr_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        parse_wav_byte(b, eof, got, r);
        if (got)
            header_reports_due.push_back(typed ? want : r);
        bytes_sent++;
        if (eof)
            files_sent++;
    endtask

    task automatic wait_drained();
        while (header_reports_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_word(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(w[8*i +: 8]);
    endtask

    function automatic logic [15:0] pick_chan();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [15:0] pick_bits();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'(8 * $urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(8000, 192000);
        endcase
    endfunction

    // Fill file_q with one file; tight forces an empty chunk and data at the end
    task automatic build_file(input t_file_kind kind, input bit tight);
        logic [31:0] ids[3];
        logic [15:0] chan;
        logic [15:0] bits;
        logic [15:0] align;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [31:0] sz;
        int          nchunks;
        int          hdr_len;
        int          tail;
        file_q.delete();
        if (kind == FK_NOISE) begin
            repeat ($urandom_range(1, 40))
                file_q.push_back(8'($urandom));
        end else begin
            ids = '{ID_RIFF, ID_WAVE, ID_FMT};
            if (kind == FK_BAD_ID)
                ids[$urandom_range(2)] ^= 32'd1 << $urandom_range(31);
            chan  = pick_chan();
            bits  = pick_bits();
            rate  = pick_rate();
            brate = (rate * {16'd0, chan} * {16'd0, bits}) >> 3;
            align = 16'(({16'd0, chan} * {16'd0, bits}) >> 3);
            if (kind == FK_BAD_RATE)
                brate ^= 32'd1 << $urandom_range(31);
            if (kind == FK_BAD_ALIGN)
                align ^= 16'd1 << $urandom_range(15);
            // RIFF header and fmt chunk
            put_word(ids[0], 4);
            put_word($urandom, 4);
            put_word(ids[1], 4);
            put_word(ids[2], 4);
            put_word($urandom, 4);
            put_word($urandom, 2);
            put_word({16'd0, chan}, 2);
            put_word(rate, 4);
            put_word(brate, 4);
            put_word({16'd0, align}, 2);
            put_word({16'd0, bits}, 2);
            if (kind == FK_HUGE_SKIP) begin
                // Chunk too large to skip before the file ends
                put_word($urandom, 4);
                put_word($urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(15)
                                           : 32'h8000_0000, 4);
                repeat ($urandom_range(0, 10))
                    file_q.push_back(8'($urandom));
            end else begin
                // Chunks to skip before data
                nchunks = tight ? 1 : $urandom_range(0, 3);
                repeat (nchunks) begin
                    sz = (tight || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    put_word($urandom, 4);
                    put_word(sz, 4);
                    repeat (sz)
                        file_q.push_back(8'($urandom));
                end
                put_word(ID_DATA, 4);
                case ($urandom_range(5))
                    0:       put_word(32'd0, 4);
                    1:       put_word(32'hFFFF_FFFF, 4);
                    default: put_word($urandom, 4);
                endcase
                hdr_len = file_q.size();
                tail = (tight || $urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                repeat (tail)
                    file_q.push_back(8'($urandom));
                // Cut the file before the data header is complete
                if (kind == FK_TRUNC) begin
                    tail = $urandom_range(1, hdr_len - 1);
                    while (file_q.size() > tail)
                        void'(file_q.pop_back());
                end
            end
        end
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1, 1'b0, INVALID_HDR);
    endtask

    // Receiver: random stalls, long hold-off on request, and report checking
    always @(posedge i_clk) begin
        t_hdr_result seen;
        t_hdr_result want;
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[28:16],
                    m_axis_tdata[60:29], m_axis_tdata[92:61], m_axis_tdata[124:93]};
            reports_seen++;
            if (!seen.status)
                reports_valid++;
            if (header_reports_due.size() == 0) begin
                flag_mismatch("report with none due", 32'(seen.status), 32'd0);
            end else begin
                want = header_reports_due.pop_front();
                if (seen.status !== want.status)
                    flag_mismatch("status", 32'(seen.status), 32'(want.status));
                if (seen.chan !== want.chan)
                    flag_mismatch("channel_count", 32'(seen.chan), 32'(want.chan));
                if (seen.bps !== want.bps)
                    flag_mismatch("bytes_per_sample", 32'(seen.bps), 32'(want.bps));
                if (seen.rate !== want.rate)
                    flag_mismatch("sample_rate", seen.rate, want.rate);
                if (seen.offset !== want.offset)
                    flag_mismatch("data_offset", seen.offset, want.offset);
                if (seen.size !== want.size)
                    flag_mismatch("data_size", seen.size, want.size);
                if (m_axis_tdata[127:125] !== 3'd0)
                    flag_mismatch("tdata padding", 32'(m_axis_tdata[127:125]), 32'd0);
            end
        end
    end

    // Stimulus
    initial begin
        int         mode;
        int         want_mode;
        int         rnd_files;
        int         pick;
        t_file_kind kind;
        reset_parse_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int i = 0; i < NUM_DIR; i++)
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].eof, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // Hold the receiver off so that one-byte files stall behind a pending report
        hold_req = 1'b1;
        repeat (24)
            send_byte(8'($urandom), 1'b1, 1'b0, INVALID_HDR);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Generated files, first one of each kind, then a weighted mix
        mode      = 0;
        rnd_files = 0;
        while (bytes_sent < 2000) begin
            want_mode = (bytes_sent < 700) ? 0 : (bytes_sent < 1400) ? 1 : 2;
            if (want_mode != mode) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                mode = want_mode;
                send_idle_pct = (mode == 1) ? 70 : 0;
                recv_idle_pct = (mode == 1) ? 14 : 0;
            end
            if (rnd_files < NUM_KINDS) begin
                kind = t_file_kind'(rnd_files);
            end else begin
                pick = $urandom_range(99);
                kind = (pick < 45) ? FK_VALID :
                       (pick < 55) ? FK_BAD_ID :
                       (pick < 62) ? FK_BAD_RATE :
                       (pick < 69) ? FK_BAD_ALIGN :
                       (pick < 85) ? FK_TRUNC :
                       (pick < 92) ? FK_HUGE_SKIP : FK_NOISE;
            end
            build_file(kind, rnd_files == 0);
            send_file();
            rnd_files++;
        end

        // Drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge i_clk);
        while (header_reports_due.size() != 0) begin
            flag_mismatch("report never arrived", 32'd0, 32'd1);
            void'(header_reports_due.pop_front());
        end

        $display("Streamed %0d files (%0d bytes) under three stall patterns.",
                 files_sent, bytes_sent);
        $display("Checked %0d header reports: %0d valid, %0d rejected or truncated.",
                 reports_seen, reports_valid, reports_seen - reports_valid);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wavhp_pkg.sv
hdl/wavhp_dpath.sv
hdl/wavhp_ctrl.sv
hdl/wav_header_parser.sv
sim/tb_top.sv
